@@ rtl/core/pst_pkg.sv @@
// Shared types, constants and helpers for the particle step pipeline.
// No dependencies.
package pst_pkg;

  localparam int DEF_FRAC_BITS = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 20;
  localparam int SQRT_STEPS    = 21;
  localparam int DIV_STEPS     = 20;
  localparam logic [10:0] DT_MAX = 11'd1966;
  localparam logic [16:0] Q16_HALF = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY  = 4'd0,
    REG_FRICTION = 4'd1,
    REG_BOUNCE   = 4'd2,
    REG_LIMIT    = 4'd3,
    REG_RADIUS   = 4'd4,
    REG_WIDTH    = 4'd5,
    REG_HEIGHT   = 4'd6,
    REG_REST     = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] gravity_accel;
    logic [15:0] friction_factor;
    logic [15:0] bounce_factor;
    logic [18:0] speed_limit;
    logic [15:0] particle_radius;
    logic [18:0] arena_width;
    logic [18:0] arena_height;
    logic [18:0] rest_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [19:0] pos_x_in;
    logic signed [19:0] pos_y_in;
    logic signed [19:0] vel_x_in;
    logic signed [19:0] vel_y_in;
    logic [15:0]        step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] pos_x_out;
    logic signed [19:0] pos_y_out;
    logic signed [19:0] vel_x_out;
    logic signed [19:0] vel_y_out;
  } out_item_t;

  // item context carried through the sqrt and rescale stages
  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [20:0] vx;
    logic signed [20:0] vy;
    logic [10:0]        dt;
    logic               over;
  } ctx_t;

  // Q0.16 product rounded to nearest
  function automatic logic [23:0] round_q16(input logic [39:0] p);
    logic [40:0] s;
    s = {1'b0, p} + 41'(Q16_HALF);
    return s[39:16];
  endfunction

  function automatic logic [19:0] mag20(input logic signed [20:0] v);
    logic [20:0] m;
    m = v[20] ? 21'(-v) : v;
    return m[19:0];
  endfunction

  // magnitude m, negated when neg is set
  function automatic logic signed [20:0] signed_as(input logic neg, input logic [19:0] m);
    logic signed [20:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    if (v > 24'sd524287) begin
      return 20'sd524287;
    end else if (v < -24'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

endpackage

@@ rtl/core/pst_cfg.sv @@
// Configuration register file for the particle step block.
// Depends on pst_pkg.
module pst_cfg #(
  parameter int FRAC_BITS = pst_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [pst_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pst_pkg::CFG_DATA_W-1:0] wr_data,
  output pst_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_accel   <= 20'(32'd1200 << FRAC_BITS);
      cfg.friction_factor <= 16'd62915;
      cfg.bounce_factor   <= 16'd3277;
      cfg.speed_limit     <= 19'(32'd900 << FRAC_BITS);
      cfg.particle_radius <= 16'(32'd4 << FRAC_BITS);
      cfg.arena_width     <= 19'(32'd800 << FRAC_BITS);
      cfg.arena_height    <= 19'(32'd600 << FRAC_BITS);
      cfg.rest_speed      <= 19'(32'd60 << FRAC_BITS);
    end else if (wr_en) begin
      unique case (wr_index)
        pst_pkg::REG_GRAVITY:  cfg.gravity_accel   <= wr_data;
        pst_pkg::REG_FRICTION: cfg.friction_factor <= wr_data[15:0];
        pst_pkg::REG_BOUNCE:   cfg.bounce_factor   <= wr_data[15:0];
        pst_pkg::REG_LIMIT:    cfg.speed_limit     <= wr_data[18:0];
        pst_pkg::REG_RADIUS:   cfg.particle_radius <= wr_data[15:0];
        pst_pkg::REG_WIDTH:    cfg.arena_width     <= wr_data[18:0];
        pst_pkg::REG_HEIGHT:   cfg.arena_height    <= wr_data[18:0];
        pst_pkg::REG_REST:     cfg.rest_speed      <= wr_data[18:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/pst_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on pst_pkg.
module pst_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [40:0]   in_s2,
  input  pst_pkg::ctx_t in_ctx,
  output logic          out_vld,
  output logic [20:0]   out_root,
  output pst_pkg::ctx_t out_ctx
);

  localparam int N = pst_pkg::SQRT_STEPS;

  logic [40:0]   x   [0:N];
  logic [41:0]   rs  [0:N];
  pst_pkg::ctx_t ctx [0:N];
  logic [N:0]    vld;

  assign x[0]   = in_s2;
  assign rs[0]  = '0;
  assign ctx[0] = in_ctx;
  assign vld[0] = in_vld;

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam int SH = 2 * (N - 1 - i);
    logic [41:0] bitv;
    logic [41:0] trial;
    assign bitv  = 42'(1) << SH;
    assign trial = rs[i] + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        ctx[i+1] <= ctx[i];
        if ({1'b0, x[i]} >= trial) begin
          x[i+1]  <= 41'({1'b0, x[i]} - trial);
          rs[i+1] <= (rs[i] >> 1) + bitv;
        end else begin
          x[i+1]  <= x[i];
          rs[i+1] <= rs[i] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_root = rs[N][20:0];
  assign out_ctx  = ctx[N];

endmodule

@@ rtl/core/pst_rescale.sv @@
// Speed rescale: v * limit / len for both components, rounded,
// as a registered numerator stage and a restoring divider pipeline. Depends on pst_pkg.
module pst_rescale (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [20:0]   in_len,
  input  logic [18:0]   limit,
  input  pst_pkg::ctx_t in_ctx,
  output logic          out_vld,
  output logic [19:0]   out_qx,
  output logic [19:0]   out_qy,
  output pst_pkg::ctx_t out_ctx
);

  localparam int N = pst_pkg::DIV_STEPS;

  logic [39:0]   rx  [0:N];
  logic [39:0]   ry  [0:N];
  logic [19:0]   qx  [0:N];
  logic [19:0]   qy  [0:N];
  logic [20:0]   len [0:N];
  pst_pkg::ctx_t ctx [0:N];
  logic [N:0]    vld;

  // numerators with the rounding half of the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rx[0]  <= 40'(pst_pkg::mag20(in_ctx.vx)) * 40'(limit) + 40'(in_len >> 1);
      ry[0]  <= 40'(pst_pkg::mag20(in_ctx.vy)) * 40'(limit) + 40'(in_len >> 1);
      len[0] <= in_len;
      ctx[0] <= in_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam int SH = N - 1 - i;
    logic [40:0] dsh;
    assign dsh = 41'(len[i]) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        len[i+1] <= len[i];
        ctx[i+1] <= ctx[i];
        if ({1'b0, rx[i]} >= dsh) begin
          rx[i+1] <= 40'({1'b0, rx[i]} - dsh);
          qx[i+1] <= qx[i] | (20'(1) << SH);
        end else begin
          rx[i+1] <= rx[i];
          qx[i+1] <= qx[i];
        end
        if ({1'b0, ry[i]} >= dsh) begin
          ry[i+1] <= 40'({1'b0, ry[i]} - dsh);
          qy[i+1] <= qy[i] | (20'(1) << SH);
        end else begin
          ry[i+1] <= ry[i];
          qy[i+1] <= qy[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_vld = vld[N];
  assign out_qx  = qx[N];
  assign out_qy  = qy[N];
  assign out_ctx = ctx[N];

endmodule

@@ rtl/core/particle_step_with_wall_bounce_top.sv @@
// Particle Euler step with wall bounce: one item per cycle while the output is not stalled.
// Items pass through the 21-stage square root and the 21-stage rescale;
// the whole pipeline advances together when the output register is free or taken.
// Synchronous reset clears all valid bits and loads the default registers.
// Depends on pst_pkg, pst_cfg, pst_sqrt, pst_rescale.
module particle_step_with_wall_bounce_top #(
  parameter int POS_FRAC_BITS = pst_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pst_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pst_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pst_pkg::CFG_DATA_W-1:0] cfg_data
);

  pst_pkg::cfg_t cfg;
  logic          en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  pst_cfg #(.FRAC_BITS(POS_FRAC_BITS)) u_cfg (
    .clk, .rst,
    .wr_en(cfg_valid), .wr_index(cfg_index), .wr_data(cfg_data), .cfg
  );

  // ---- S1: clamp dt, gravity and friction products
  logic [10:0]        dtc;
  logic [10:0]        s1_dt;
  logic [30:0]        s1_gdt;
  logic [35:0]        s1_fx;
  logic               s1_xneg;
  logic signed [19:0] s1_px, s1_py, s1_vy;

  assign dtc = (in_data.step_time > 16'(pst_pkg::DT_MAX)) ? pst_pkg::DT_MAX
                                                           : in_data.step_time[10:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dt   <= dtc;
      s1_gdt  <= cfg.gravity_accel * dtc;
      s1_fx   <= pst_pkg::mag20(21'(in_data.vel_x_in)) * cfg.friction_factor;
      s1_xneg <= in_data.vel_x_in[19];
      s1_px   <= in_data.pos_x_in;
      s1_py   <= in_data.pos_y_in;
      s1_vy   <= in_data.vel_y_in;
    end
  end

  // ---- S2: new velocities
  pst_pkg::ctx_t s2_ctx;
  logic [23:0]   g_rnd, f_rnd;
  assign g_rnd = pst_pkg::round_q16(40'(s1_gdt));
  assign f_rnd = pst_pkg::round_q16(40'(s1_fx));

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctx.px   <= s1_px;
      s2_ctx.py   <= s1_py;
      s2_ctx.vx   <= pst_pkg::signed_as(s1_xneg, f_rnd[19:0]);
      s2_ctx.vy   <= 21'(s1_vy) + $signed({1'b0, g_rnd[19:0]});
      s2_ctx.dt   <= s1_dt;
      s2_ctx.over <= 1'b0;
    end
  end

  // ---- S3: squares
  pst_pkg::ctx_t s3_ctx;
  logic [39:0]   s3_sqx, s3_sqy;
  logic [37:0]   s3_lim2;
  logic [19:0]   s2_mx, s2_my;
  assign s2_mx = pst_pkg::mag20(s2_ctx.vx);
  assign s2_my = pst_pkg::mag20(s2_ctx.vy);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctx  <= s2_ctx;
      s3_sqx  <= s2_mx * s2_mx;
      s3_sqy  <= s2_my * s2_my;
      s3_lim2 <= cfg.speed_limit * cfg.speed_limit;
    end
  end

  // ---- S4: sum of squares and limit check
  pst_pkg::ctx_t s4_ctx, s3_tag;
  logic [40:0]   s4_s2, s3_sum;
  assign s3_sum = 41'(s3_sqx) + 41'(s3_sqy);

  always_comb begin
    s3_tag      = s3_ctx;
    s3_tag.over = s3_sum > 41'(s3_lim2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_s2  <= s3_sum;
      s4_ctx <= s3_tag;
    end
  end

  logic [4:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:1], in_valid};
    end
  end

  // ---- square root and rescale
  logic          sq_vld, rs_vld;
  logic [20:0]   sq_root;
  pst_pkg::ctx_t sq_ctx, rs_ctx;
  logic [19:0]   rs_qx, rs_qy;

  pst_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_vld(vld[4]), .in_s2(s4_s2), .in_ctx(s4_ctx),
    .out_vld(sq_vld), .out_root(sq_root), .out_ctx(sq_ctx)
  );

  pst_rescale u_rescale (
    .clk, .rst, .en,
    .in_vld(sq_vld), .in_len(sq_root), .limit(cfg.speed_limit), .in_ctx(sq_ctx),
    .out_vld(rs_vld), .out_qx(rs_qx), .out_qy(rs_qy), .out_ctx(rs_ctx)
  );

  // ---- S5: pick velocity, displacement products
  logic signed [20:0] vx5, vy5;
  logic signed [20:0] s5_vx, s5_vy;
  logic signed [19:0] s5_px, s5_py;
  logic [30:0]        s5_dx, s5_dy;

  assign vx5 = rs_ctx.over ? pst_pkg::signed_as(rs_ctx.vx[20], rs_qx) : rs_ctx.vx;
  assign vy5 = rs_ctx.over ? pst_pkg::signed_as(rs_ctx.vy[20], rs_qy) : rs_ctx.vy;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vx <= vx5;
      s5_vy <= vy5;
      s5_px <= rs_ctx.px;
      s5_py <= rs_ctx.py;
      s5_dx <= pst_pkg::mag20(vx5) * rs_ctx.dt;
      s5_dy <= pst_pkg::mag20(vy5) * rs_ctx.dt;
    end
  end

  // ---- S6: move
  logic signed [20:0] s6_vx, s6_vy;
  logic signed [22:0] s6_px, s6_py;
  logic [23:0]        dx_rnd, dy_rnd;
  assign dx_rnd = pst_pkg::round_q16(40'(s5_dx));
  assign dy_rnd = pst_pkg::round_q16(40'(s5_dy));

  always_ff @(posedge clk) begin
    if (en) begin
      s6_vx <= s5_vx;
      s6_vy <= s5_vy;
      s6_px <= 23'(s5_px) + 23'(pst_pkg::signed_as(s5_vx[20], dx_rnd[19:0]));
      s6_py <= 23'(s5_py) + 23'(pst_pkg::signed_as(s5_vy[20], dy_rnd[19:0]));
    end
  end

  // ---- S7: wall and floor checks, bounce products
  logic signed [23:0] rad, wid, hgt, pxl;
  logic               hit_floor, hit_left, hit_right;
  logic signed [20:0] s7_vx, s7_vy;
  logic signed [23:0] s7_px, s7_py;
  logic               s7_floor, s7_left, s7_right;
  logic [35:0]        s7_bx, s7_by;

  assign rad       = $signed({8'b0, cfg.particle_radius});
  assign wid       = $signed({5'b0, cfg.arena_width});
  assign hgt       = $signed({5'b0, cfg.arena_height});
  assign hit_floor = 24'(s6_py) + rad > hgt;
  assign hit_left  = 24'(s6_px) - rad < 24'sd0;
  assign pxl       = hit_left ? rad : 24'(s6_px);
  assign hit_right = pxl + rad > wid;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_vx    <= s6_vx;
      s7_vy    <= s6_vy;
      s7_px    <= hit_right ? wid - rad : pxl;
      s7_py    <= hit_floor ? hgt - rad : 24'(s6_py);
      s7_floor <= hit_floor;
      s7_left  <= hit_left;
      s7_right <= hit_right;
      s7_bx    <= pst_pkg::mag20(s6_vx) * cfg.bounce_factor;
      s7_by    <= pst_pkg::mag20(s6_vy) * cfg.bounce_factor;
    end
  end

  // ---- S8: floor rebound, left wall rebound
  logic [23:0]        bx_rnd, by_rnd;
  logic signed [20:0] s8_vx, s8_vy;
  logic signed [23:0] s8_px, s8_py;
  logic               s8_right;
  assign bx_rnd = pst_pkg::round_q16(40'(s7_bx));
  assign by_rnd = pst_pkg::round_q16(40'(s7_by));

  always_ff @(posedge clk) begin
    if (en) begin
      s8_px    <= s7_px;
      s8_py    <= s7_py;
      s8_right <= s7_right;
      if (s7_floor) begin
        // slow rebounds come to rest
        s8_vy <= (by_rnd[19:0] < 20'(cfg.rest_speed)) ? '0
               : pst_pkg::signed_as(!s7_vy[20], by_rnd[19:0]);
      end else begin
        s8_vy <= s7_vy;
      end
      s8_vx <= s7_left ? pst_pkg::signed_as(!s7_vx[20], bx_rnd[19:0]) : s7_vx;
    end
  end

  // ---- S9: right wall product (may follow a left bounce)
  logic signed [20:0] s9_vx, s9_vy;
  logic signed [23:0] s9_px, s9_py;
  logic               s9_right;
  logic [35:0]        s9_bx;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_vx    <= s8_vx;
      s9_vy    <= s8_vy;
      s9_px    <= s8_px;
      s9_py    <= s8_py;
      s9_right <= s8_right;
      s9_bx    <= pst_pkg::mag20(s8_vx) * cfg.bounce_factor;
    end
  end

  // ---- S10: output register with saturation
  logic [23:0]        bx2_rnd;
  logic signed [20:0] vx10;
  logic [9:5]         vld_b;
  assign bx2_rnd = pst_pkg::round_q16(40'(s9_bx));
  assign vx10    = s9_right ? pst_pkg::signed_as(!s9_vx[20], bx2_rnd[19:0]) : s9_vx;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.pos_x_out <= pst_pkg::sat20(s9_px);
      out_data.pos_y_out <= pst_pkg::sat20(s9_py);
      out_data.vel_x_out <= pst_pkg::sat20(24'(vx10));
      out_data.vel_y_out <= pst_pkg::sat20(24'(s9_vy));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_b     <= {vld_b[8:5], rs_vld};
      out_valid <= vld_b[9];
    end
  end

endmodule
